/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the capture sequencer unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent on the same edge.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Condition must never hold.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

/* design/iscs_pkg.sv */
// ----------------------------------------------------------------------------
// iscs_pkg
// Types and constants for the image sensor capture sequencer.
// ----------------------------------------------------------------------------
package iscs_pkg;

    localparam int PIXEL_COUNT = 16384;
    localparam int REG_COUNT   = 8;
    localparam int ADDR_BITS   = 3;

    localparam int PIX_W      = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int CFG_NUM    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [3:0]       LAST_BIT  = 4'(ADDR_BITS + 7);
    localparam logic [2:0]       REG_LAST  = 3'(REG_COUNT - 1);
    localparam logic [PIX_W-1:0] PIX_LAST  = PIX_W'(PIXEL_COUNT - 1);

    localparam logic [2:0] RESET_PULSE_TICK = 3'd4;
    localparam logic [2:0] RESET_LAST_TICK  = 3'd5;

    // Sensor register reset values, in send order
    localparam logic [7:0] REG_DEFAULTS [CFG_NUM] = '{
        8'h7F, 8'h02, 8'h00, 8'd90, 8'h01, 8'h00, 8'h01, 8'h04
    };

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_RESET = 3'd1,
        PH_PROG  = 3'd2,
        PH_START = 3'd3,
        PH_WAIT  = 3'd4,
        PH_READ  = 3'd5
    } phase_t;

    typedef struct packed {
        logic       capture;
        logic       read_level;
        logic [7:0] sample;
    } in_item_t;

    typedef struct packed {
        logic       sensor_clock;
        logic       sensor_reset_n;
        logic       sensor_load;
        logic       sensor_data;
        logic       sensor_start;
        logic       pixel_valid;
        logic [7:0] pixel_value;
        logic       last_pixel;
        logic       busy_res;
    } out_item_t;

endpackage

/* design/iscs_cfg.sv */
// ----------------------------------------------------------------------------
// iscs_cfg
// Sensor settings register file with one read port for the serializer.
// ----------------------------------------------------------------------------
module iscs_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [iscs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iscs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [2:0]                      rd_index,
    output logic [7:0]                      rd_data
);
    import iscs_pkg::*;

    logic [7:0] regs_reg [CFG_NUM];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_NUM; i++)
            begin
                regs_reg[i] <= REG_DEFAULTS[i];
            end
        end
        else if (cfg_we)
        begin
            regs_reg[cfg_index] <= cfg_wdata;
        end
    end

    assign rd_data = regs_reg[rd_index];

endmodule

/* design/iscs_seq.sv */
// ----------------------------------------------------------------------------
// iscs_seq
// Per-tick sequencer: reset, register programming, start, READ wait, readout.
// ----------------------------------------------------------------------------
module iscs_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  iscs_pkg::in_item_t  item,
    input  logic [7:0]          cfg_byte,
    output logic [2:0]          cfg_sel,
    output iscs_pkg::out_item_t result
);
    import iscs_pkg::*;

    phase_t           phase_reg,    phase_next;
    logic [2:0]       half_reg,     half_next;
    logic [3:0]       bit_reg,      bit_next;
    logic [2:0]       regidx_reg,   regidx_next;
    logic [PIX_W-1:0] pix_reg,      pix_next;
    logic             clk_lvl_reg,  clk_lvl_next;
    logic             rst_pin_reg,  rst_pin_next;
    logic             load_pin_reg, load_pin_next;
    logic             data_pin_reg, data_pin_next;
    logic             start_pin_reg, start_pin_next;

    logic       cur_bit;
    logic [3:0] addr_shift;
    logic [3:0] data_pos;
    logic [7:0] addr_byte;

    assign cfg_sel = regidx_reg;

    // Bit being shifted out: address MSB first, then settings byte MSB first
    always_comb
    begin
        addr_shift = 4'(ADDR_BITS - 1) - bit_reg;
        data_pos   = bit_reg - 4'(ADDR_BITS);
        addr_byte  = {5'd0, regidx_reg};
        if (bit_reg < 4'(ADDR_BITS))
        begin
            cur_bit = addr_byte[addr_shift[2:0]];
        end
        else
        begin
            cur_bit = cfg_byte[3'd7 - data_pos[2:0]];
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        half_next      = half_reg;
        bit_next       = bit_reg;
        regidx_next    = regidx_reg;
        pix_next       = pix_reg;
        clk_lvl_next   = clk_lvl_reg;
        rst_pin_next   = rst_pin_reg;
        load_pin_next  = load_pin_reg;
        data_pin_next  = data_pin_reg;
        start_pin_next = start_pin_reg;
        result         = '0;

        if (phase_next == PH_IDLE && item.capture)
        begin
            phase_next = PH_RESET;
            half_next  = 3'd0;
        end
        result.busy_res = (phase_next != PH_IDLE);

        case (phase_next)
            PH_RESET:
            begin
                clk_lvl_next = ~half_next[0];
                rst_pin_next = (half_next != RESET_PULSE_TICK);
                if (half_next >= RESET_LAST_TICK)
                begin
                    phase_next  = PH_PROG;
                    half_next   = 3'd0;
                    bit_next    = 4'd0;
                    regidx_next = 3'd0;
                end
                else
                begin
                    half_next = half_next + 3'd1;
                end
            end
            PH_PROG:
            begin
                if (half_next == 3'd0)
                begin
                    data_pin_next = cur_bit;
                    load_pin_next = (bit_reg == LAST_BIT);
                    clk_lvl_next  = 1'b1;
                    half_next     = 3'd1;
                end
                else
                begin
                    clk_lvl_next = 1'b0;
                    half_next    = 3'd0;
                    if (bit_reg >= LAST_BIT)
                    begin
                        bit_next = 4'd0;
                        if (regidx_reg >= REG_LAST)
                        begin
                            regidx_next = 3'd0;
                            phase_next  = PH_START;
                        end
                        else
                        begin
                            regidx_next = regidx_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        bit_next = bit_reg + 4'd1;
                    end
                end
            end
            PH_START:
            begin
                load_pin_next = 1'b0;
                if (half_next == 3'd0)
                begin
                    start_pin_next = 1'b1;
                    clk_lvl_next   = 1'b1;
                    half_next      = 3'd1;
                end
                else
                begin
                    start_pin_next = 1'b0;
                    clk_lvl_next   = 1'b0;
                    half_next      = 3'd0;
                    phase_next     = PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                // READ is looked at only while the clock rests low
                if (!clk_lvl_reg)
                begin
                    if (item.read_level)
                    begin
                        phase_next = PH_READ;
                        pix_next   = '0;
                        half_next  = 3'd0;
                    end
                    else
                    begin
                        clk_lvl_next = 1'b1;
                    end
                end
                else
                begin
                    clk_lvl_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        // Readout may start on the same tick READ was seen
        if (phase_next == PH_READ)
        begin
            if (half_next == 3'd0)
            begin
                clk_lvl_next = 1'b1;
                half_next    = 3'd1;
            end
            else
            begin
                clk_lvl_next       = 1'b0;
                half_next          = 3'd0;
                result.pixel_valid = 1'b1;
                result.pixel_value = item.sample;
                if (pix_next >= PIX_LAST)
                begin
                    result.last_pixel = 1'b1;
                    pix_next          = '0;
                    phase_next        = PH_IDLE;
                end
                else
                begin
                    pix_next = pix_next + PIX_W'(1);
                end
            end
        end

        result.sensor_clock   = clk_lvl_next;
        result.sensor_reset_n = rst_pin_next;
        result.sensor_load    = load_pin_next;
        result.sensor_data    = data_pin_next;
        result.sensor_start   = start_pin_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            half_reg      <= 3'd0;
            bit_reg       <= 4'd0;
            regidx_reg    <= 3'd0;
            pix_reg       <= '0;
            clk_lvl_reg   <= 1'b0;
            rst_pin_reg   <= 1'b1;
            load_pin_reg  <= 1'b0;
            data_pin_reg  <= 1'b0;
            start_pin_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            half_reg      <= half_next;
            bit_reg       <= bit_next;
            regidx_reg    <= regidx_next;
            pix_reg       <= pix_next;
            clk_lvl_reg   <= clk_lvl_next;
            rst_pin_reg   <= rst_pin_next;
            load_pin_reg  <= load_pin_next;
            data_pin_reg  <= data_pin_next;
            start_pin_reg <= start_pin_next;
        end
    end

endmodule

/* design/image_sensor_capture_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// image_sensor_capture_sequencer_unit
// Capture sequencer for a serially programmed image sensor, one beat per
// sensor clock half-period.
//
//   Channel  Signals                             Beat
//   -------  ----------------------------------  -----------------------------
//   in       in_valid / in_stall / in_item       one half-period tick
//   out      out_valid / out_stall / out_item    pin levels and pixel for tick
//   cfg      cfg_we / cfg_index / cfg_wdata      one sensor settings byte
//
// Each beat passes an input register, the sequencer step and an output
// register; one beat per cycle sustained while the output is not stalled.
// A full picture is a reset, a programming pass over all REG_COUNT registers,
// a start pulse, the READ wait and the readout of all PIXEL_COUNT pixels.
// Reset clears control state and loads the sensor register defaults.
// A stalled output holds; the input stalls only when both stages are full.
// ----------------------------------------------------------------------------
module image_sensor_capture_sequencer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  iscs_pkg::in_item_t              in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output iscs_pkg::out_item_t             out_item,
    input  logic                            cfg_we,
    input  logic [iscs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iscs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import iscs_pkg::*;

    `include "assert_macros.svh"

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      advance;
    logic      in_take;
    out_item_t step_result;
    logic [2:0] cfg_sel;
    logic [7:0] cfg_byte;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    iscs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rd_index  (cfg_sel),
        .rd_data   (cfg_byte)
    );

    iscs_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .item     (in_item_reg),
        .cfg_byte (cfg_byte),
        .cfg_sel  (cfg_sel),
        .result   (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_item_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `ASSERT_IMPLIES(a_last_has_pixel, clk, rst_n, out_valid && out_item.last_pixel, out_item.pixel_valid)
    `ASSERT_IMPLIES(a_pixel_when_busy, clk, rst_n, out_valid && out_item.pixel_valid, out_item.busy_res)
    `ASSERT_IMPLIES(a_no_pixel_zero, clk, rst_n, out_valid && !out_item.pixel_valid, out_item.pixel_value == 8'd0)
    `ASSERT_NEVER(a_stall_needs_item, clk, rst_n, in_stall && !in_valid_reg)

endmodule

/* bench/pin_level_scoreboard.sv */
// ----------------------------------------------------------------------------
// pin_level_scoreboard
// Watches the tick and pin-level channels of the capture sequencer and the
// settings write port. Every accepted tick is run through a local model of
// the sequencer; the pin levels it yields are queued and compared, field by
// field, with the beats that leave the block.
// ----------------------------------------------------------------------------
module pin_level_scoreboard
    import iscs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  in_item_t               in_item,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  out_item_t              out_item,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                     fail_count,
    output int                     pending,
    output int                     frames_done
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_LEN    = ADDR_BITS;
    localparam int FINAL_BIT   = ADDR_BITS + 7;
    localparam int FINAL_REG   = REG_COUNT - 1;
    localparam int FINAL_PIXEL = PIXEL_COUNT - 1;
    localparam int PRINT_CAP   = 20;

    localparam logic [7:0] SETTING_RESET [8] = '{
        8'h7F, 8'h02, 8'h00, 8'd90, 8'h01, 8'h00, 8'h01, 8'h04
    };

    // local copy of sequencer state and sensor settings
    phase_t     seq_phase;
    logic [2:0] tick;
    logic [3:0] bit_pos;
    logic [2:0] reg_sel;
    int         pix_cnt;
    logic       clk_lvl;
    logic       pin_rst_n;
    logic       pin_load;
    logic       pin_data;
    logic       pin_start;
    logic [7:0] sensor_regs [8];

    out_item_t  pin_levels_q [$];
    int         out_beats;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (fail_count < PRINT_CAP)
            $display("[%0t] out beat %0d: %s got %0h expected %0h",
                     $realtime, out_beats, what, got, want);
        fail_count++;
    endtask

    task automatic compare_field(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // bit currently on the serial line: address MSB first, then data MSB first
    function automatic logic prog_bit();
        if (bit_pos < ADDR_LEN)
            return reg_sel[ADDR_LEN - 1 - bit_pos];
        return sensor_regs[reg_sel][7 - (bit_pos - ADDR_LEN)];
    endfunction

    function automatic out_item_t advance_sensor_tick(input in_item_t beat);
        out_item_t res;
        res = '0;
        if (seq_phase == PH_IDLE && beat.capture)
        begin
            seq_phase = PH_RESET;
            tick      = 3'd0;
        end
        res.busy_res = (seq_phase != PH_IDLE);

        case (seq_phase)
            PH_RESET:
            begin
                clk_lvl   = ~tick[0];
                pin_rst_n = (tick != 3'd4);
                if (tick >= 3'd5)
                begin
                    seq_phase = PH_PROG;
                    tick      = 3'd0;
                    bit_pos   = 4'd0;
                    reg_sel   = 3'd0;
                end
                else
                    tick = tick + 3'd1;
            end
            PH_PROG:
            begin
                if (tick == 3'd0)
                begin
                    pin_data = prog_bit();
                    pin_load = (bit_pos == FINAL_BIT);
                    clk_lvl  = 1'b1;
                    tick     = 3'd1;
                end
                else
                begin
                    clk_lvl = 1'b0;
                    tick    = 3'd0;
                    if (bit_pos >= FINAL_BIT)
                    begin
                        bit_pos = 4'd0;
                        if (reg_sel >= FINAL_REG)
                        begin
                            reg_sel   = 3'd0;
                            seq_phase = PH_START;
                        end
                        else
                            reg_sel = reg_sel + 3'd1;
                    end
                    else
                        bit_pos = bit_pos + 4'd1;
                end
            end
            PH_START:
            begin
                pin_load = 1'b0;
                if (tick == 3'd0)
                begin
                    pin_start = 1'b1;
                    clk_lvl   = 1'b1;
                    tick      = 3'd1;
                end
                else
                begin
                    pin_start = 1'b0;
                    clk_lvl   = 1'b0;
                    tick      = 3'd0;
                    seq_phase = PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                // READ is only looked at while the clock rests low
                if (!clk_lvl)
                begin
                    if (beat.read_level)
                    begin
                        seq_phase = PH_READ;
                        pix_cnt   = 0;
                        tick      = 3'd0;
                    end
                    else
                        clk_lvl = 1'b1;
                end
                else
                    clk_lvl = 1'b0;
            end
            default: ;
        endcase

        // readout starts on the same tick READ is seen
        if (seq_phase == PH_READ)
        begin
            if (tick == 3'd0)
            begin
                clk_lvl = 1'b1;
                tick    = 3'd1;
            end
            else
            begin
                clk_lvl         = 1'b0;
                tick            = 3'd0;
                res.pixel_valid = 1'b1;
                res.pixel_value = beat.sample;
                if (pix_cnt >= FINAL_PIXEL)
                begin
                    res.last_pixel = 1'b1;
                    pix_cnt        = 0;
                    seq_phase      = PH_IDLE;
                end
                else
                    pix_cnt++;
            end
        end

        res.sensor_clock   = clk_lvl;
        res.sensor_reset_n = pin_rst_n;
        res.sensor_load    = pin_load;
        res.sensor_data    = pin_data;
        res.sensor_start   = pin_start;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            seq_phase = PH_IDLE;
            tick      = 3'd0;
            bit_pos   = 4'd0;
            reg_sel   = 3'd0;
            pix_cnt   = 0;
            clk_lvl   = 1'b0;
            pin_rst_n = 1'b1;
            pin_load  = 1'b0;
            pin_data  = 1'b0;
            pin_start = 1'b0;
            for (int i = 0; i < 8; i++)
                sensor_regs[i] = SETTING_RESET[i];
            pin_levels_q.delete();
            out_beats   = 0;
            fail_count  = 0;
            pending     = 0;
            frames_done = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pin_levels_q.size() == 0)
                    report_mismatch("beat with nothing expected", out_item[7:0], 8'h00);
                else
                begin
                    want = pin_levels_q.pop_front();
                    compare_field("sensor_clock",   8'(out_item.sensor_clock),
                                  8'(want.sensor_clock));
                    compare_field("sensor_reset_n", 8'(out_item.sensor_reset_n),
                                  8'(want.sensor_reset_n));
                    compare_field("sensor_load",    8'(out_item.sensor_load),
                                  8'(want.sensor_load));
                    compare_field("sensor_data",    8'(out_item.sensor_data),
                                  8'(want.sensor_data));
                    compare_field("sensor_start",   8'(out_item.sensor_start),
                                  8'(want.sensor_start));
                    compare_field("pixel_valid",    8'(out_item.pixel_valid),
                                  8'(want.pixel_valid));
                    compare_field("pixel_value",    out_item.pixel_value,    want.pixel_value);
                    compare_field("last_pixel",     8'(out_item.last_pixel),
                                  8'(want.last_pixel));
                    compare_field("busy_res",       8'(out_item.busy_res),
                                  8'(want.busy_res));
                    if (want.last_pixel)
                        frames_done++;
                end
                out_beats++;
            end
            if (cfg_we)
                sensor_regs[cfg_index] = cfg_wdata;
            if (in_valid && !in_stall)
                pin_levels_q.push_back(advance_sensor_tick(in_item));
            pending = pin_levels_q.size();
        end
    end

endmodule

/* bench/image_sensor_capture_sequencer_unit_tb.sv */
// ----------------------------------------------------------------------------
// image_sensor_capture_sequencer_unit_tb
// Drives sensor-clock ticks into the capture sequencer: a few idle ticks at
// the field extremes, then one capture sequence carried on through several
// settings loads and idle/stall mixes, into the pixel readout. Checking is
// done by the scoreboard; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module image_sensor_capture_sequencer_unit_tb;
    import iscs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 9;
    localparam int NUM_PHASES   = 5;
    localparam int PHASE_TICKS  = 78;
    localparam int SETTLE       = 8;
    localparam int RUN_LIMIT_NS = 200_000;
    // ticks from the capture request to the first READ look
    localparam int SETUP_TICKS  = 6 + 2 * REG_COUNT * (ADDR_BITS + 8) + 2;

    typedef enum int { SET_ZERO, SET_ONES, SET_RANDOM } setting_mix_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    int frames_done;
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int ticks_sent   = 0;
    int cfg_writes   = 0;
    int seq_tick     = 0;
    int ready_tick   = 0;

    int gap_mix   [NUM_PHASES] = '{0, 45, 0, 23, 0};
    int stall_mix [NUM_PHASES] = '{0, 0, 45, 23, 0};

    image_sensor_capture_sequencer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    pin_level_scoreboard scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .pending     (pending),
        .frames_done (frames_done)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);

    task automatic send_tick(input logic cap, input logic rd, input logic [7:0] smp);
        in_item_t beat;
        beat.capture    = cap;
        beat.read_level = rd;
        beat.sample     = smp;
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ticks_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic load_settings(input setting_mix_t mix);
        for (int i = 0; i < CFG_NUM; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            case (mix)
                SET_ZERO: cfg_wdata <= 8'h00;
                SET_ONES: cfg_wdata <= 8'hFF;
                default:  cfg_wdata <= 8'($urandom_range(255));
            endcase
            cfg_writes++;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // next n ticks of the picture; READ is low at every look before
    // ready_tick and goes high there
    task automatic run_capture(input int n);
        logic rd;
        for (int k = 0; k < n; k++)
        begin
            if (seq_tick == ready_tick)
                rd = 1'b1;
            else if (seq_tick >= SETUP_TICKS && seq_tick < ready_tick &&
                     ((seq_tick - SETUP_TICKS) % 2 == 0))
                rd = 1'b0;
            else
                rd = 1'($urandom_range(1));
            // capture while busy must be ignored
            send_tick((seq_tick == 0) ? 1'b1 : 1'($urandom_range(1)), rd,
                      8'($urandom_range(255)));
            seq_tick++;
        end
    endtask

    initial
    begin
        int read_checks;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // idle ticks at the field extremes
        send_tick(1'b0, 1'b0, 8'h00);
        send_tick(1'b0, 1'b1, 8'hFF);
        send_tick(1'b0, 1'b1, 8'h00);
        send_tick(1'b0, 1'b0, 8'hFF);
        send_tick(1'b0, 1'b1, 8'h80);
        send_tick(1'b0, 1'b0, 8'h01);
        send_tick(1'b0, 1'b1, 8'h55);
        send_tick(1'b0, 1'b0, 8'hAA);

        // zero looks means READ is already high at the first look
        read_checks = $urandom_range(8, 0);
        ready_tick  = SETUP_TICKS + 2 * read_checks;

        // the loads in phases 1 and 2 land while registers are shifted out
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            case (ph)
                0: ;                        // reset settings
                1: load_settings(SET_ZERO);
                2: load_settings(SET_ONES);
                default: load_settings(SET_RANDOM);
            endcase
            send_gap_pct = gap_mix[ph];
            stall_pct    = stall_mix[ph];
            run_capture(PHASE_TICKS);
        end

        drain();
        stall_pct = 0;
        repeat (SETTLE) @(negedge clk);

        $display("covered %0d ticks, %0d settings writes, %0d complete pictures",
                 ticks_sent, cfg_writes, frames_done);
        $display("mixes: no idling, sender gaps, receiver stalls, both; READ after %0d looks",
                 read_checks);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d beats still expected", pending);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/iscs_pkg.sv
design/iscs_cfg.sv
design/iscs_seq.sv
design/image_sensor_capture_sequencer_unit.sv
bench/pin_level_scoreboard.sv
bench/image_sensor_capture_sequencer_unit_tb.sv
